// File: rtl/sgnst_pkg.sv
// Shared types, constants and helpers of the noise spectrum tracker.
`default_nettype none
package sgnst_pkg;

    // Spectrum geometry
    localparam int BINS        = 129;
    localparam int IDX_W       = $clog2(BINS);
    localparam int CNT_W       = $clog2(BINS + 1);
    localparam int BIN_INDEX_W = 8;

    // Fixed-point widths
    localparam int PWR_W  = 32;
    localparam int Q16_W  = 17;
    localparam int SUM_W  = 40;
    localparam int DIVD_W = SUM_W + 1;
    localparam int STEP_W = $clog2(DIVD_W + 1);
    localparam int PROD_W = PWR_W + Q16_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [Q16_W-1:0] Q16_ONE  = 17'h10000;
    localparam logic [Q16_W-1:0] Q16_HALF = 17'h08000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 2'd1;

    localparam logic [Q16_W-1:0] RATE_BASE_RST = 17'd3277;
    localparam logic [Q16_W-1:0] DECAY_RST     = 17'd64881;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified bin on its way to the back part
    typedef struct packed {
        logic [PWR_W-1:0] x;
        logic [Q16_W-1:0] lr;
        logic [IDX_W-1:0] idx;
        logic             last;
    } queue_item_t;

    // Clamp a Q1.16 value to 1.0
    function automatic logic [Q16_W-1:0] sat_one(input logic [Q16_W-1:0] v);
        sat_one = (v > Q16_ONE) ? Q16_ONE : v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sgnst_front.sv
// Front part: accepts bins, tracks the bin position and works out the learning rate.
`default_nettype none
module sgnst_front (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [sgnst_pkg::Q16_W-1:0]      rate_base,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [sgnst_pkg::PWR_W-1:0]      s_signal_power,
    input  wire  [sgnst_pkg::Q16_W-1:0]      s_speech_prob,
    input  wire                              s_frame_end,
    output logic                             push_valid,
    input  wire                              push_ready,
    output sgnst_pkg::queue_item_t           push_item
);
    import sgnst_pkg::*;

    logic             stage_valid_reg, stage_valid_next;
    logic [PWR_W-1:0] x_reg;
    logic [Q16_W-1:0] p_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             last_reg;
    logic [IDX_W-1:0] bin_cnt_reg, bin_cnt_next;
    logic             accept;
    logic             cur_last;
    logic [33:0]      lr_prod;
    logic [33:0]      lr_round;
    logic [17:0]      lr_raw;
    logic [Q16_W-1:0] lr;

    assign s_ready    = !stage_valid_reg || push_ready;
    assign accept     = s_valid && s_ready;
    assign push_valid = stage_valid_reg;

    // Frame position: a bin at the top index always closes the frame
    assign cur_last     = s_frame_end || (bin_cnt_reg == IDX_W'(BINS - 1));
    assign bin_cnt_next = cur_last ? '0 : bin_cnt_reg + 1'b1;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (accept) begin
            stage_valid_next = 1'b1;
        end else if (push_ready) begin
            stage_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            bin_cnt_reg     <= '0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            if (accept) begin
                bin_cnt_reg <= bin_cnt_next;
            end
        end
    end

    // Payload stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= s_signal_power;
            p_reg    <= sat_one(s_speech_prob);
            idx_reg  <= bin_cnt_reg;
            last_reg <= cur_last;
        end
    end

    // lr = round(rate_base * (1 - p)), clamped to 1.0
    assign lr_prod  = 34'(rate_base) * 34'(Q16_ONE - p_reg);
    assign lr_round = lr_prod + 34'(Q16_HALF);
    assign lr_raw   = lr_round[33:16];
    assign lr       = (lr_raw > 18'(Q16_ONE)) ? Q16_ONE : lr_raw[Q16_W-1:0];

    assign push_item.x    = x_reg;
    assign push_item.lr   = lr;
    assign push_item.idx  = idx_reg;
    assign push_item.last = last_reg;

endmodule
`default_nettype wire

// File: rtl/sgnst_queue.sv
// Short first-in first-out queue between the front and back parts.
`default_nettype none
module sgnst_queue (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       push_valid,
    output logic                      push_ready,
    input  sgnst_pkg::queue_item_t    push_item,
    output logic                      pop_valid,
    input  wire                       pop_ready,
    output sgnst_pkg::queue_item_t    pop_item
);
    import sgnst_pkg::*;

    queue_item_t       slot_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_item   = slot_mem[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sgnst_div.sv
// Restoring divider, one quotient bit per cycle, for the frame mean.
`default_nettype none
module sgnst_div (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  wire  [sgnst_pkg::DIVD_W-1:0] dividend,
    input  wire  [sgnst_pkg::CNT_W-1:0]  divisor,
    output logic                         done,
    output logic [sgnst_pkg::PWR_W-1:0]  quotient
);
    import sgnst_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVD_W-1:0] quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    // One trial subtraction per cycle
    assign trial = {rem_reg, quo_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], ge};
            rem_reg <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    assign done     = done_reg;
    // Saturate to 32 bits
    assign quotient = (|quo_reg[DIVD_W-1:PWR_W]) ? '1 : quo_reg[PWR_W-1:0];

endmodule
`default_nettype wire

// File: rtl/sgnst_back.sv
// Back part: per-bin noise and conservative update, stores, frame sum and result register.
`default_nettype none
module sgnst_back (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire  [sgnst_pkg::Q16_W-1:0]       decay_factor,
    input  wire                               pop_valid,
    output logic                              pop_ready,
    input  sgnst_pkg::queue_item_t            pop_item,
    output logic                              m_valid,
    input  wire                               m_ready,
    output logic [sgnst_pkg::BIN_INDEX_W-1:0] m_bin_index,
    output logic [sgnst_pkg::PWR_W-1:0]       m_noise_level,
    output logic [sgnst_pkg::PWR_W-1:0]       m_conservative_level,
    output logic [sgnst_pkg::PWR_W-1:0]       m_mean_noise,
    output logic                              m_last
);
    import sgnst_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL_X = 7'b0000010,
        ST_MUL_N = 7'b0000100,
        ST_MUL_C = 7'b0001000,
        ST_FIN   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } back_state_t;

    back_state_t state_reg, state_next;

    // Bin stores with per-entry valid bits (invalid reads as 1.0)
    logic [PWR_W-1:0] noise_mem [BINS];
    logic [PWR_W-1:0] cons_mem  [BINS];
    logic [BINS-1:0]  written_reg;
    logic [PWR_W-1:0] noise_q_reg, cons_q_reg;
    logic             written_q_reg;
    logic [PWR_W-1:0] n_eff, c_eff;

    queue_item_t      item_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg;
    logic [Q16_W-1:0]  mul_a;
    logic [PWR_W-1:0]  mul_b;
    logic [SUM_W-1:0]  sum_reg;
    logic [PWR_W-1:0]  noise_reg, cons_reg;

    logic [ACC_W-1:0]  noise_sum;
    logic [33:0]       noise_raw;
    logic [PWR_W-1:0]  noise_val;
    logic [ACC_W-1:0]  dec_sum;
    logic [33:0]       dec_raw;
    logic [33:0]       cons_raw;
    logic [PWR_W-1:0]  cons_val;
    logic [SUM_W:0]    sum_add;
    logic [SUM_W-1:0]  sum_new;
    logic [CNT_W-1:0]  bin_cnt;
    logic [DIVD_W-1:0] dividend;

    logic              do_pop, fin, div_start, div_done, out_load;
    logic [PWR_W-1:0]  div_quo;
    logic              m_valid_reg;
    logic [BIN_INDEX_W-1:0] bin_index_reg;
    logic [PWR_W-1:0]  m_noise_reg, m_cons_reg, m_mean_reg;
    logic              m_last_reg;

    assign pop_ready = (state_reg == ST_IDLE);
    assign do_pop    = pop_valid && pop_ready;
    assign fin       = (state_reg == ST_FIN);
    assign div_start = fin && item_reg.last;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (pop_valid) state_next = ST_MUL_X;
            ST_MUL_X: state_next = ST_MUL_N;
            ST_MUL_N: state_next = ST_MUL_C;
            ST_MUL_C: state_next = ST_FIN;
            ST_FIN:   state_next = item_reg.last ? ST_DIV : ST_OUT;
            ST_DIV:   if (div_done) state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Store read at pop, write at finish
    always_ff @(posedge aclk) begin
        if (do_pop) begin
            noise_q_reg <= noise_mem[pop_item.idx];
            cons_q_reg  <= cons_mem[pop_item.idx];
        end
        if (fin) begin
            noise_mem[item_reg.idx] <= noise_val;
            cons_mem[item_reg.idx]  <= cons_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end else begin
            if (do_pop) begin
                written_q_reg <= written_reg[pop_item.idx];
            end
            if (fin) begin
                written_reg[item_reg.idx] <= 1'b1;
            end
        end
    end

    assign n_eff = written_q_reg ? noise_q_reg : PWR_W'(Q16_ONE);
    assign c_eff = written_q_reg ? cons_q_reg  : PWR_W'(Q16_ONE);

    // Shared multiplier: lr*x, then (1-lr)*n, then c*decay
    always_comb begin
        mul_a = item_reg.lr;
        mul_b = item_reg.x;
        unique case (state_reg)
            ST_MUL_N: begin
                mul_a = Q16_ONE - item_reg.lr;
                mul_b = n_eff;
            end
            ST_MUL_C: begin
                mul_a = decay_factor;
                mul_b = c_eff;
            end
            default: begin
                mul_a = item_reg.lr;
                mul_b = item_reg.x;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            item_reg <= pop_item;
        end
        if (state_reg == ST_MUL_X || state_reg == ST_MUL_N || state_reg == ST_MUL_C) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_MUL_N) begin
            acc_reg <= ACC_W'(prod_reg);
        end else if (state_reg == ST_MUL_C) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Rounding, saturation and the conservative maximum
    assign noise_sum = acc_reg + ACC_W'(Q16_HALF);
    assign noise_raw = noise_sum[49:16];
    assign noise_val = (|noise_raw[33:32]) ? '1 : noise_raw[PWR_W-1:0];
    assign dec_sum   = ACC_W'(prod_reg) + ACC_W'(Q16_HALF);
    assign dec_raw   = dec_sum[49:16];
    assign cons_raw  = (dec_raw > 34'(noise_val)) ? dec_raw : 34'(noise_val);
    assign cons_val  = (|cons_raw[33:32]) ? '1 : cons_raw[PWR_W-1:0];

    // Frame energy sum, saturating
    assign sum_add  = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(noise_val);
    assign sum_new  = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    assign bin_cnt  = CNT_W'(item_reg.idx) + 1'b1;
    assign dividend = DIVD_W'(sum_new) + DIVD_W'(bin_cnt >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else if (fin) begin
            sum_reg <= item_reg.last ? '0 : sum_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin) begin
            noise_reg <= noise_val;
            cons_reg  <= cons_val;
        end
    end

    sgnst_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (bin_cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            bin_index_reg <= BIN_INDEX_W'(item_reg.idx);
            m_noise_reg   <= noise_reg;
            m_cons_reg    <= cons_reg;
            m_mean_reg    <= item_reg.last ? div_quo : '0;
            m_last_reg    <= item_reg.last;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_bin_index          = bin_index_reg;
    assign m_noise_level        = m_noise_reg;
    assign m_conservative_level = m_cons_reg;
    assign m_mean_noise         = m_mean_reg;
    assign m_last               = m_last_reg;

endmodule
`default_nettype wire

// File: rtl/speech_gated_noise_spectrum_tracker_unit.sv
// Top level of the speech-gated noise spectrum tracker.
//
//   Channel   Prefix   Handshake        Moves
//   input     s_       s_valid/s_ready  one bin: power, speech probability, frame end
//   result    m_       m_valid/m_ready  one bin result, frame mean on the last bin
//   config    cfg_     cfg_wr_en        register write, no wait, no read-back
//
// A bin passes through the back part as store read, three passes through the
// shared 17x32 multiplier, finish and result load; the frame's last bin also
// waits for the one-bit-per-cycle mean divider. Reset is synchronous, active
// low; stores read as 1.0 until first written. A stalled result register holds
// the back part; the two-entry queue and the front stage keep taking bins until full.
`default_nettype none
module speech_gated_noise_spectrum_tracker_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                cfg_wr_en,
    input  wire  [sgnst_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [sgnst_pkg::Q16_W-1:0]        cfg_wr_data,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire  [sgnst_pkg::PWR_W-1:0]        s_signal_power,
    input  wire  [sgnst_pkg::Q16_W-1:0]        s_speech_prob,
    input  wire                                s_frame_end,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic [sgnst_pkg::BIN_INDEX_W-1:0]  m_bin_index,
    output logic [sgnst_pkg::PWR_W-1:0]        m_noise_level,
    output logic [sgnst_pkg::PWR_W-1:0]        m_conservative_level,
    output logic [sgnst_pkg::PWR_W-1:0]        m_mean_noise,
    output logic                               m_last
);
    import sgnst_pkg::*;

    logic [Q16_W-1:0] rate_base_reg;
    logic [Q16_W-1:0] decay_reg;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    queue_item_t      push_item, pop_item;

    // Configuration registers, clamped to 1.0; other indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_base_reg <= RATE_BASE_RST;
            decay_reg     <= DECAY_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_RATE_BASE: rate_base_reg <= sat_one(cfg_wr_data);
                CFG_DECAY:     decay_reg <= sat_one(cfg_wr_data);
                default: begin
                end
            endcase
        end
    end

    sgnst_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rate_base      (rate_base_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_signal_power (s_signal_power),
        .s_speech_prob  (s_speech_prob),
        .s_frame_end    (s_frame_end),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    sgnst_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sgnst_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .decay_factor         (decay_reg),
        .pop_valid            (pop_valid),
        .pop_ready            (pop_ready),
        .pop_item             (pop_item),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin_index          (m_bin_index),
        .m_noise_level        (m_noise_level),
        .m_conservative_level (m_conservative_level),
        .m_mean_noise         (m_mean_noise),
        .m_last               (m_last)
    );

`ifndef ASSERT_OFF
    // Conservative estimate never falls below the noise estimate
    a_cons_ge_noise: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_conservative_level >= m_noise_level))
        else $error("conservative level below noise level");

    // Mean is only carried on a frame's last bin
    a_mean_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_mean_noise == '0))
        else $error("mean noise set on a non-final bin");

    // The top bin always closes the frame
    a_top_bin_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_bin_index == BIN_INDEX_W'(BINS - 1))) |-> m_last)
        else $error("top bin result without last");
`endif

endmodule
`default_nettype wire

// File: dv/sgnst_checker.sv
// Checker for the noise spectrum tracker: watches the channels, predicts each bin result, compares.
`default_nettype none
module sgnst_checker
    import sgnst_pkg::*;
(
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     cfg_wr_en,
    input  wire  [CFG_IDX_W-1:0]    cfg_index,
    input  wire  [Q16_W-1:0]        cfg_wr_data,
    input  wire                     s_valid,
    input  wire                     s_ready,
    input  wire  [PWR_W-1:0]        s_signal_power,
    input  wire  [Q16_W-1:0]        s_speech_prob,
    input  wire                     s_frame_end,
    input  wire                     m_valid,
    input  wire                     m_ready,
    input  wire  [BIN_INDEX_W-1:0]  m_bin_index,
    input  wire  [PWR_W-1:0]        m_noise_level,
    input  wire  [PWR_W-1:0]        m_conservative_level,
    input  wire  [PWR_W-1:0]        m_mean_noise,
    input  wire                     m_last,
    output int                      mismatches,
    output int                      waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned UNIT     = 64'd65536;
    localparam longint unsigned HALF     = 64'd32768;
    localparam longint unsigned WORD_MAX = 64'hFFFF_FFFF;
    localparam longint unsigned SUM_MAX  = 64'hFF_FFFF_FFFF;

    // One bin result as it should leave the block
    typedef struct packed {
        logic [BIN_INDEX_W-1:0] bin_index;
        logic [PWR_W-1:0]       noise;
        logic [PWR_W-1:0]       cons;
        logic [PWR_W-1:0]       mean;
        logic                   last;
    } bin_result_t;

    // Predicted tracker state and register copies
    logic [PWR_W-1:0] noise_track [BINS];
    logic [PWR_W-1:0] cons_track  [BINS];
    int unsigned      next_bin;
    longint unsigned  frame_energy;
    logic [Q16_W-1:0] rate_reg;
    logic [Q16_W-1:0] decay_reg;
    bin_result_t      bin_results_due [$];
    int               err_cnt;

    function automatic logic [Q16_W-1:0] clamp_unit(input logic [Q16_W-1:0] v);
        return (v > UNIT) ? UNIT[Q16_W-1:0] : v;
    endfunction

    function automatic longint unsigned clamp_word(input longint unsigned v);
        return (v > WORD_MAX) ? WORD_MAX : v;
    endfunction

    // Update the noise tracks of the next bin and work out its result
    function automatic bin_result_t track_bin(input logic [PWR_W-1:0] pwr,
                                              input logic [Q16_W-1:0] prob,
                                              input logic fend);
        longint unsigned p, lr, n_old, c_old, n_new, decayed, c_new, sum, cnt;
        longint unsigned mean_w;
        int unsigned     idx;
        bin_result_t     r;
        idx   = (next_bin >= BINS) ? BINS - 1 : next_bin;
        p     = 64'(clamp_unit(prob));
        lr    = (64'(rate_reg) * (UNIT - p) + HALF) >> 16;
        if (lr > UNIT) lr = UNIT;
        n_old = 64'(noise_track[idx]);
        c_old = 64'(cons_track[idx]);
        n_new = clamp_word((lr * 64'(pwr) + (UNIT - lr) * n_old + HALF) >> 16);
        decayed = (c_old * 64'(decay_reg) + HALF) >> 16;
        c_new = clamp_word((decayed > n_new) ? decayed : n_new);
        noise_track[idx] = n_new[PWR_W-1:0];
        cons_track[idx]  = c_new[PWR_W-1:0];
        sum = frame_energy + n_new;
        if (sum > SUM_MAX) sum = SUM_MAX;
        r.last = fend || (idx == BINS - 1);
        r.mean = '0;
        if (r.last) begin
            cnt          = 64'(idx) + 64'd1;
            mean_w       = clamp_word((sum + cnt / 2) / cnt);
            r.mean       = mean_w[PWR_W-1:0];
            next_bin     = 0;
            frame_energy = 0;
        end else begin
            next_bin     = idx + 1;
            frame_energy = sum;
        end
        r.bin_index = idx[BIN_INDEX_W-1:0];
        r.noise     = n_new[PWR_W-1:0];
        r.cons      = c_new[PWR_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string what, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
            err_cnt++;
        end
    endtask

    // Watch config writes and both channels
    always @(posedge aclk) begin
        bin_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < BINS; i++) begin
                noise_track[i] = UNIT[PWR_W-1:0];
                cons_track[i]  = UNIT[PWR_W-1:0];
            end
            rate_reg     = RATE_BASE_RST;
            decay_reg    = DECAY_RST;
            next_bin     = 0;
            frame_energy = 0;
            err_cnt      = 0;
            bin_results_due.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_RATE_BASE) rate_reg = clamp_unit(cfg_wr_data);
                else if (cfg_index == CFG_DECAY) decay_reg = clamp_unit(cfg_wr_data);
            end
            // result transaction against the oldest prediction
            if (m_valid && m_ready) begin
                if (bin_results_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual bin %0d noise 0x%0h",
                             $time, m_bin_index, m_noise_level);
                    err_cnt++;
                end else begin
                    want = bin_results_due.pop_front();
                    check_field("bin_index", 64'(want.bin_index), 64'(m_bin_index));
                    check_field("noise_level", 64'(want.noise), 64'(m_noise_level));
                    check_field("conservative_level", 64'(want.cons),
                                64'(m_conservative_level));
                    check_field("mean_noise", 64'(want.mean), 64'(m_mean_noise));
                    check_field("last", 64'(want.last), 64'(m_last));
                end
            end
            if (s_valid && s_ready)
                bin_results_due.push_back(track_bin(s_signal_power, s_speech_prob, s_frame_end));
        end
        mismatches <= err_cnt;
        waiting    <= bin_results_due.size();
    end

endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Testbench top of the noise spectrum tracker: clock, reset, stimulus and verdict.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sgnst_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_TICKS = 64;     // past the back part and mean divider
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 170;

    // unused register slots, writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam logic [PWR_W-1:0] PWR_MAX  = 32'hFFFF_FFFF;
    localparam logic [Q16_W-1:0] Q16_FULL = 17'h1FFFF;

    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index      = '0;
    logic [Q16_W-1:0]       cfg_wr_data    = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [PWR_W-1:0]       s_signal_power = '0;
    logic [Q16_W-1:0]       s_speech_prob  = '0;
    logic                   s_frame_end    = 1'b0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [BIN_INDEX_W-1:0] m_bin_index;
    logic [PWR_W-1:0]       m_noise_level;
    logic [PWR_W-1:0]       m_conservative_level;
    logic [PWR_W-1:0]       m_mean_noise;
    logic                   m_last;

    int mismatches;
    int waiting;
    int cycles     = 0;
    int burst_left = 0;

    speech_gated_noise_spectrum_tracker_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_signal_power       (s_signal_power),
        .s_speech_prob        (s_speech_prob),
        .s_frame_end          (s_frame_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin_index          (m_bin_index),
        .m_noise_level        (m_noise_level),
        .m_conservative_level (m_conservative_level),
        .m_mean_noise         (m_mean_noise),
        .m_last               (m_last)
    );

    sgnst_checker i_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wr_data          (cfg_wr_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_signal_power       (s_signal_power),
        .s_speech_prob        (s_speech_prob),
        .s_frame_end          (s_frame_end),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin_index          (m_bin_index),
        .m_noise_level        (m_noise_level),
        .m_conservative_level (m_conservative_level),
        .m_mean_noise         (m_mean_noise),
        .m_last               (m_last),
        .mismatches           (mismatches),
        .waiting              (waiting)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure: mode changes now and then
    int unsigned rdy_mode     = 0;
    int unsigned rdy_mode_left = 0;
    int unsigned rdy_run_left = 0;
    always @(posedge aclk) begin
        if (rdy_mode_left == 0) begin
            rdy_mode      <= $urandom_range(0, 3);
            rdy_mode_left <= $urandom_range(64, 300);
        end else begin
            rdy_mode_left <= rdy_mode_left - 1;
        end
        case (rdy_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) != 0);
            2: m_ready <= ($urandom_range(0, 7) != 0);
            default: begin
                // long stall and ready runs
                if (rdy_run_left == 0) begin
                    m_ready      <= ~m_ready;
                    rdy_run_left <= $urandom_range(1, 20);
                end else begin
                    rdy_run_left <= rdy_run_left - 1;
                end
            end
        endcase
    end

    // Register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q16_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(posedge aclk);
    endtask

    // One bin transaction, then the sender's burst and gap pattern
    task automatic send_bin(input logic [PWR_W-1:0] pwr, input logic [Q16_W-1:0] prob,
                            input logic fend);
        int unsigned gap;
        s_valid        <= 1'b1;
        s_signal_power <= pwr;
        s_speech_prob  <= prob;
        s_frame_end    <= fend;
        do @(posedge aclk); while (!s_ready);
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(0, 30);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold the sender until every predicted result is out
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
    endtask

    function automatic logic [PWR_W-1:0] rand_power;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PWR_MAX;
            2, 3:    return $urandom_range(0, 32'h0004_0000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [Q16_W-1:0] rand_prob;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return Q16_ONE;
            2:       return Q16_W'($urandom_range(65537, 131071));
            3:       return Q16_W'($urandom_range(0, 131071));
            default: return Q16_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [Q16_W-1:0] rand_level;
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return Q16_ONE;
            2:       return Q16_W'($urandom_range(0, 131071));
            3:       return Q16_W'($urandom_range(0, 8000));
            default: return Q16_W'($urandom_range(60000, 65536));
        endcase
    endfunction

    task automatic send_frame(input int len, input logic closed);
        for (int i = 0; i < len; i++)
            send_bin(rand_power(), rand_prob(), closed && (i == len - 1));
    endtask

    // Mostly well-formed frames, some overlong ones and some noise
    task automatic random_frames(input int quota);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < quota) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                len = $urandom_range(1, 12);
                send_frame(len, 1'b1);
            end else if (kind < 70) begin
                len = $urandom_range(13, 60);
                send_frame(len, 1'b1);
            end else if (kind < 75) begin
                len = BINS;
                send_frame(len, 1'b1);
            end else if (kind < 79) begin
                // no frame end: the last bin index closes it
                len = BINS + $urandom_range(0, 5);
                send_frame(len, 1'b0);
            end else begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++)
                    send_bin(rand_power(), rand_prob(), $urandom_range(0, 3) == 0);
            end
            sent += len;
        end
    endtask

    initial begin
        logic [Q16_W-1:0] rate_set;
        logic [Q16_W-1:0] decay_set;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: field extremes, saturating probability, short frames
        send_bin(PWR_MAX, '0, 1'b0);
        send_bin('0, Q16_ONE, 1'b0);
        send_bin(32'h0001_0000, Q16_FULL, 1'b0);
        send_bin($urandom, 17'd65537, 1'b1);
        send_bin(PWR_MAX, '0, 1'b1);
        send_bin('0, '0, 1'b1);
        drain();

        // Saturating rate write, zero decay, spare indexes ignored
        write_reg(CFG_RATE_BASE, Q16_FULL);
        write_reg(CFG_DECAY, '0);
        write_reg(CFG_SPARE_LO, Q16_FULL);
        write_reg(CFG_SPARE_HI, '0);
        send_bin(PWR_MAX, '0, 1'b0);
        send_bin(PWR_MAX, '0, 1'b0);
        send_bin('0, '0, 1'b0);
        send_bin(PWR_MAX, 17'd32768, 1'b1);
        send_bin(32'h5555_5555, 17'h0AAAA, 1'b1);
        drain();

        // Frozen noise, no decay
        write_reg(CFG_RATE_BASE, '0);
        write_reg(CFG_DECAY, Q16_ONE);
        send_bin(PWR_MAX, '0, 1'b0);
        send_bin('0, Q16_ONE, 1'b1);
        drain();

        // Random phases, each under its own register settings
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin rate_set = '0;          decay_set = Q16_ONE;     end
                1: begin rate_set = Q16_ONE;     decay_set = '0;          end
                2: begin rate_set = RATE_BASE_RST; decay_set = DECAY_RST; end
                3: begin rate_set = Q16_FULL;    decay_set = 17'd65537;   end
                default: begin rate_set = rand_level(); decay_set = rand_level(); end
            endcase
            write_reg(CFG_RATE_BASE, rate_set);
            write_reg(CFG_DECAY, decay_set);
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI,
                      Q16_W'($urandom_range(0, 131071)));
            random_frames(PHASE_ITEMS);
            drain();
        end

        repeat (SETTLE_TICKS) @(posedge aclk);
        if (mismatches == 0 && waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
`default_nettype wire
